@@ rtl/core/dfr_pkg.sv @@
// dfr_pkg: types, constants and codes for the datagram fragment reassembler
// no dependencies
`default_nettype none
package dfr_pkg;
    localparam int FRAG_PAYLOAD = 256;
    localparam int MAX_FRAGS    = 16;
    localparam int MAX_MESSAGE  = 4096;
    localparam int HEADER_LEN   = 14;
    localparam int ADDR_W       = $clog2(MAX_MESSAGE);
    localparam int POS_W        = 10;
    localparam int QDEPTH       = 2;
    localparam logic [7:0] ANY_TYPE = 8'hff;

    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_ARM  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;
    localparam logic [1:0] ACT_READ = 2'd3;

    localparam logic [2:0] ST_DROP    = 3'd0;
    localparam logic [2:0] ST_TAKEN   = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    localparam logic [2:0] REG_TYPE     = 3'd0;
    localparam logic [2:0] REG_SESSION  = 3'd1;
    localparam logic [2:0] REG_CAPACITY = 3'd2;
    localparam logic [2:0] REG_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_MAGIC    = 3'd4;
    localparam logic [2:0] REG_VERSION  = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  data_byte;
        logic        end_of_datagram;
        logic [31:0] source_addr;
        logic [15:0] source_port_in;
        logic [11:0] read_offset;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  message_type;
        logic [31:0] session_id;
        logic [12:0] message_length;
        logic [31:0] sender_addr;
        logic [15:0] sender_port;
        logic [15:0] framed_bytes;
        logic [7:0]  read_data;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  exp_type;
        logic [31:0] exp_session;
        logic [12:0] capacity;
        logic [31:0] timeout;
        logic [15:0] magic;
        logic [7:0]  version;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]  action;
        logic        fin;
        logic [7:0]  data_byte;
        logic [31:0] addr;
        logic [15:0] port;
        logic [11:0] read_offset;
        logic        pay;
        logic [7:0]  q;
        logic [POS_W-1:0] len;
        logic        ov;
        logic        hdr_ok;
        logic        len_ok;
        logic [7:0]  h_type;
        logic [31:0] h_session;
        logic [15:0] h_total;
        logic [7:0]  h_index;
        logic [7:0]  h_count;
        logic [15:0] h_payload;
    } t_cmd;
endpackage
`default_nettype wire

@@ rtl/core/dfr_ram.sv @@
// dfr_ram: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/dfr_front.sv @@
// dfr_front: byte parser, header capture and static header checks
// depends on dfr_pkg
`default_nettype none
module dfr_front import dfr_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_cmd          o_cmd
);
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_ov, n_ov;
    logic [7:0]       r_hdr [HEADER_LEN];
    logic [7:0]       hb [HEADER_LEN];
    logic             r_valid;
    t_cmd             r_cmd, n_cmd;
    logic             take, is_byte, in_hdr, in_pay, at_limit;

    function automatic logic expected_any(input logic [7:0] t);
        expected_any = t == ANY_TYPE;
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
    assign take    = i_valid && o_ready;
    assign is_byte = i_item.action == ACT_BYTE;
    assign at_limit = r_pos >= POS_W'(HEADER_LEN + FRAG_PAYLOAD);
    assign in_hdr  = r_pos < POS_W'(HEADER_LEN);
    assign in_pay  = !at_limit && !in_hdr && !r_ov;

    always_comb begin
        for (int k = 0; k < HEADER_LEN; k++) begin
            hb[k] = (in_hdr && r_pos == POS_W'(k)) ? i_item.data_byte : r_hdr[k];
        end
    end

    always_comb begin
        logic [POS_W-1:0] len;
        len = at_limit ? r_pos : r_pos + POS_W'(1);
        n_pos = r_pos;
        n_ov  = r_ov;
        if (take && is_byte) begin
            if (i_item.end_of_datagram) begin
                n_pos = '0;
                n_ov  = 1'b0;
            end else if (at_limit) begin
                n_ov = 1'b1;
            end else begin
                n_pos = len;
            end
        end
        n_cmd.action      = i_item.action;
        n_cmd.fin         = i_item.end_of_datagram;
        n_cmd.data_byte   = i_item.data_byte;
        n_cmd.addr        = i_item.source_addr;
        n_cmd.port        = i_item.source_port_in;
        n_cmd.read_offset = i_item.read_offset;
        n_cmd.pay         = in_pay;
        n_cmd.q           = 8'(r_pos - POS_W'(HEADER_LEN));
        n_cmd.len         = len;
        n_cmd.ov          = r_ov || at_limit;
        n_cmd.h_type      = hb[3];
        n_cmd.h_session   = {hb[4], hb[5], hb[6], hb[7]};
        n_cmd.h_total     = {hb[8], hb[9]};
        n_cmd.h_index     = hb[10];
        n_cmd.h_count     = hb[11];
        n_cmd.h_payload   = {hb[12], hb[13]};
        n_cmd.hdr_ok = {hb[0], hb[1]} == i_cfg.magic && hb[2] == i_cfg.version
            && hb[11] != 8'd0 && hb[11] <= 8'(MAX_FRAGS) && hb[10] < hb[11]
            && {hb[12], hb[13]} <= 16'(FRAG_PAYLOAD)
            && {hb[8], hb[9]} <= 16'(MAX_MESSAGE)
            && ((expected_any(i_cfg.exp_type)) || hb[3] == i_cfg.exp_type)
            && (i_cfg.exp_session == 32'd0
                || {hb[4], hb[5], hb[6], hb[7]} == i_cfg.exp_session);
        n_cmd.len_ok = len >= POS_W'(HEADER_LEN)
            && 16'(len) == 16'(HEADER_LEN) + {hb[12], hb[13]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ov    <= 1'b0;
            r_valid <= 1'b0;
            for (int k = 0; k < HEADER_LEN; k++) begin
                r_hdr[k] <= 8'd0;
            end
        end else begin
            r_pos <= n_pos;
            r_ov  <= n_ov;
            if (o_ready) begin
                r_valid <= take;
            end
            if (take && is_byte && in_hdr) begin
                r_hdr[r_pos[3:0]] <= i_item.data_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(HEADER_LEN + FRAG_PAYLOAD))
        else $error("byte position out of range");
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && is_byte && i_item.end_of_datagram |=> r_pos == '0 && !r_ov)
        else $error("datagram end did not clear parser");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_cmd))
        else $error("stalled command changed");
endmodule
`default_nettype wire

@@ rtl/core/dfr_back.sv @@
// dfr_back: lock, bitmap, timeout and message store access
// depends on dfr_pkg and dfr_ram
`default_nettype none
module dfr_back import dfr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_cmd  i_cmd,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_out_item  o_item
);
    logic        r_armed, r_locked;
    logic [7:0]  r_ltype, r_lcount, r_done;
    logic [31:0] r_lsess, r_laddr, r_ticks;
    logic [12:0] r_llen;
    logic [15:0] r_lport, r_framed;
    logic [MAX_FRAGS-1:0] r_map;
    logic        r_valid, r_is_read, r_rd_zero;
    t_out_item   r_out;
    logic [7:0]  ram_q;
    logic        take, live, match, fit, we;
    logic [3:0]  idx;
    logic [16:0] off_end, lim;
    logic [11:0] waddr;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign live    = r_armed && r_ticks < i_cfg.timeout;
    assign idx     = i_cmd.h_index[3:0];
    assign match   = i_cmd.h_type == r_ltype && i_cmd.h_session == r_lsess
        && i_cmd.h_total == 16'(r_llen) && i_cmd.h_count == r_lcount
        && i_cmd.addr == r_laddr && i_cmd.port == r_lport;
    assign off_end = {i_cmd.h_index, 8'd0} + 17'(i_cmd.h_payload);
    assign lim     = r_locked ? 17'(r_llen) : 17'(i_cmd.h_total);
    assign fit     = off_end <= lim;
    assign waddr   = 12'({i_cmd.h_index[3:0], 8'd0} + 12'(i_cmd.q));

    always_comb begin
        logic ok;
        ok = live && i_cmd.hdr_ok
            && (r_locked ? match : i_cmd.h_total <= 16'(i_cfg.capacity));
        we = take && i_cmd.action == ACT_BYTE && i_cmd.pay && ok && fit
            && !r_map[idx] && 16'(i_cmd.q) < i_cmd.h_payload;
    end

    dfr_ram #(.WIDTH(8), .DEPTH(MAX_MESSAGE)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.data_byte),
        .i_raddr (i_cmd.read_offset),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        logic        lk;
        logic [7:0]  lt, lc, dn;
        logic [31:0] ls, la;
        logic [12:0] ll;
        logic [15:0] lp, fr;
        logic [MAX_FRAGS-1:0] mp;
        logic        ar, pass, emit;
        logic [31:0] tk;
        logic [2:0]  st;
        if (!i_rst_n) begin
            r_armed <= 1'b0; r_locked <= 1'b0;
            r_ltype <= '0; r_lcount <= '0; r_done <= '0;
            r_lsess <= '0; r_laddr <= '0; r_ticks <= '0;
            r_llen <= '0; r_lport <= '0; r_framed <= '0; r_map <= '0;
            r_valid <= 1'b0;
        end else begin
            lk = r_locked; lt = r_ltype; lc = r_lcount; dn = r_done;
            ls = r_lsess; la = r_laddr; ll = r_llen; lp = r_lport;
            fr = r_framed; mp = r_map; ar = r_armed; tk = r_ticks;
            emit = 1'b0; st = ST_DROP; pass = 1'b0;
            if (take) begin
                case (i_cmd.action)
                    ACT_BYTE: begin
                        if (i_cmd.fin) begin
                            emit = 1'b1;
                            pass = live && !i_cmd.ov && i_cmd.len_ok && i_cmd.hdr_ok;
                            if (pass && !lk) begin
                                if (i_cmd.h_total <= 16'(i_cfg.capacity)) begin
                                    lk = 1'b1; lt = i_cmd.h_type; ls = i_cmd.h_session;
                                    ll = 13'(i_cmd.h_total); lc = i_cmd.h_count;
                                    la = i_cmd.addr; lp = i_cmd.port; fr = '0;
                                end else begin
                                    pass = 1'b0;
                                end
                            end
                            if (pass && i_cmd.h_type == lt && i_cmd.h_session == ls
                                && i_cmd.h_total == 16'(ll) && i_cmd.h_count == lc
                                && i_cmd.addr == la && i_cmd.port == lp
                                && off_end <= 17'(ll)) begin
                                if (!mp[idx]) begin
                                    mp[idx] = 1'b1;
                                    dn = dn + 8'd1;
                                    fr = fr + 16'(i_cmd.len);
                                end
                                if (dn == lc) begin
                                    ar = 1'b0; st = ST_DONE;
                                end else begin
                                    st = ST_TAKEN;
                                end
                            end
                        end
                    end
                    ACT_ARM: begin
                        lk = 1'b0; lt = '0; ls = '0; ll = '0; lc = '0; la = '0;
                        lp = '0; mp = '0; dn = '0; fr = '0; tk = '0; ar = 1'b1;
                    end
                    ACT_TICK: begin
                        if (ar) begin
                            if (tk != 32'hffffffff) begin
                                tk = tk + 32'd1;
                            end
                            if (tk >= i_cfg.timeout) begin
                                ar = 1'b0; emit = 1'b1; st = ST_TIMEOUT;
                            end
                        end
                    end
                    default: begin
                        emit = 1'b1; st = ST_READ;
                    end
                endcase
            end
            r_locked <= lk; r_ltype <= lt; r_lcount <= lc; r_done <= dn;
            r_lsess <= ls; r_laddr <= la; r_llen <= ll; r_lport <= lp;
            r_framed <= fr; r_map <= mp; r_armed <= ar; r_ticks <= tk;
            if (o_ready) begin
                r_valid <= take && emit;
            end
            if (take && emit) begin
                r_out <= '{status: st, message_type: lt, session_id: ls,
                    message_length: ll, sender_addr: la, sender_port: lp,
                    framed_bytes: fr, read_data: 8'd0};
                r_is_read <= st == ST_READ;
                r_rd_zero <= 1'b0;
            end
        end
    end

    // ram data is valid the cycle after the read is taken; capture it then
    logic [7:0] r_rdata;
    logic       r_cap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 1'b0;
        end else begin
            r_cap <= take && i_cmd.action == ACT_READ;
        end
        if (r_cap) begin
            r_rdata <= ram_q;
        end
    end

    logic [7:0] rd_now;
    assign rd_now = r_cap ? ram_q : r_rdata;

    assign o_valid = r_valid;
    always_comb begin
        o_item = r_out;
        o_item.read_data = (r_is_read && !r_rd_zero) ? rd_now : 8'd0;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_out))
        else $error("stalled result changed");
    a_done_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_map) == int'(r_done))
        else $error("fragment count disagrees with bitmap");
    a_cap_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap |-> r_valid && r_is_read)
        else $error("read data captured without read result");
endmodule
`default_nettype wire

@@ rtl/core/datagram_fragment_reassembler_unit.sv @@
// datagram_fragment_reassembler_unit: top level, config registers, front and back
// depends on dfr_pkg, dfr_front, dfr_back
//
//  channel  | handshake              | payload
//  input    | i_valid / o_ready      | i_item  (t_in_item)
//  output   | o_valid / i_ready      | o_item  (t_out_item)
//  config   | i_cfg_we               | i_cfg_index, i_cfg_data
//
// one item per cycle unless stalled; front and back each hold one registered item
// results are registered in front then back, read data from the message ram
// reset clears parser, lock and timeout state; message ram is not cleared
// an output stall reaches o_ready through the ready of each registered stage
`default_nettype none
module datagram_fragment_reassembler_unit import dfr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_item    i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out_item        o_item
);
    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid, cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{exp_type: 8'hff, exp_session: 32'd0, capacity: 13'd4096,
                timeout: 32'd1000, magic: 16'd0, version: 8'd1};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TYPE:     r_cfg.exp_type    <= i_cfg_data[7:0];
                REG_SESSION:  r_cfg.exp_session <= i_cfg_data;
                REG_CAPACITY: r_cfg.capacity    <= i_cfg_data[12:0];
                REG_TIMEOUT:  r_cfg.timeout     <= i_cfg_data;
                REG_MAGIC:    r_cfg.magic       <= i_cfg_data[15:0];
                REG_VERSION:  r_cfg.version     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    dfr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(cmd_valid), .i_ready(cmd_ready), .o_cmd(cmd)
    );

    dfr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(cmd_valid), .o_ready(cmd_ready), .i_cmd(cmd),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );
endmodule
`default_nettype wire
